### rtl/register_write_stream_decoder_macros.svh
// Assertion macros for the register write stream decoder.
`ifndef REGISTER_WRITE_STREAM_DECODER_MACROS_SVH
`define REGISTER_WRITE_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define RWSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define RWSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rwsd_pkg.sv
// Types and constants shared by the register write stream decoder.
`default_nettype none
package rwsd_pkg;

  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 18;
  localparam int BASE_W    = 15;
  localparam int COUNT_W   = 6;
  localparam int FIELD_LSB = 15;
  localparam int MODE_BIT  = 31;
  localparam int TDATA_W   = 56;
  localparam int TUSER_W   = 5;

  localparam logic [COUNT_W-1:0] WEIGHTS_COUNT = 6'd2;
  localparam logic [COUNT_W-1:0] INPUT_COUNT   = 6'd10;

  typedef enum logic [2:0] {
    CTX_PLAIN      = 3'd0,
    CTX_WEIGHTS_LO = 3'd1,
    CTX_WEIGHTS_HI = 3'd2,
    CTX_INPUT      = 3'd3,
    CTX_MASKED     = 3'd4
  } ctx_t;

  typedef struct packed {
    logic [WORD_W-1:0] stream_word;
    logic              end_of_stream;
  } rwsd_cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] reg_byte_address;
    logic [WORD_W-1:0] reg_value;
    ctx_t              write_context;
    logic              block_done;
    logic              write_valid;
    logic              truncated;
  } rwsd_result_t;

endpackage
`default_nettype wire

### rtl/register_write_stream_decoder.sv
// Register write stream decoder: top level.
//
// Slave side takes one 32-bit command word per transaction; tlast marks the
// final word of the stream. Master side gives one register write per payload
// word: byte address and value in tdata, end of block on tlast, and context
// tag, write_valid and truncated flags in tuser. Header and dummy words give
// no transaction, except a header that ends the stream with payload still
// due, which gives a truncated marker with write_valid low.
//
// A payload word taken into the input register is decoded into the result
// register and offered on the master side from there. Throughput: one word
// per cycle while the master side does not stall, set by the single decode
// stage between the two registers.
//
// Reset puts the decoder back to expecting a header and empties both
// registers. When the master side stalls, the result register holds; one
// more word that gives a write may sit in the input register, after which
// s_axis_tready drops until the stall clears.
`default_nettype none
`include "register_write_stream_decoder_macros.svh"
module register_write_stream_decoder
  import rwsd_pkg::*;
#(
  parameter int MASK_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [WORD_W-1:0]  s_axis_tdata,   // [31:0] stream_word
  input  wire logic               s_axis_tlast,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [17:0] reg_byte_address, [49:18] reg_value, [55:50] zero
  output logic [TDATA_W-1:0]      m_axis_tdata,
  output logic                    m_axis_tlast,
  // [2:0] write_context, [3] write_valid, [4] truncated
  output logic [TUSER_W-1:0]      m_axis_tuser
);

  rwsd_cmd_t    in_cmd;
  rwsd_cmd_t    cmd;
  logic         cmd_valid;
  logic         cmd_take;
  rwsd_result_t res;
  logic         res_valid;
  logic         res_ready;
  rwsd_result_t out_item;

  assign in_cmd.stream_word   = s_axis_tdata;
  assign in_cmd.end_of_stream = s_axis_tlast;

  rwsd_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (in_cmd),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  rwsd_core #(
    .MASK_WIDTH (MASK_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  rwsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (out_item)
  );

  assign m_axis_tdata = {6'b000000, out_item.reg_value, out_item.reg_byte_address};
  assign m_axis_tlast = out_item.block_done;
  assign m_axis_tuser = {out_item.truncated, out_item.write_valid, out_item.write_context};

  `RWSD_ASSERT_NOW(a_marker_empty, m_axis_tvalid && !out_item.write_valid, out_item.truncated && !out_item.block_done && out_item.reg_byte_address == '0, "truncation marker carries data")
  `RWSD_ASSERT_NOW(a_weights_hi_addr, m_axis_tvalid && out_item.write_context == CTX_WEIGHTS_HI, out_item.reg_byte_address == ADDR_W'(4) && out_item.write_valid, "weights high word not at register one")
  `RWSD_ASSERT_NEXT(a_take_fills_out, res_valid && res_ready, m_axis_tvalid, "taken result lost before output")

endmodule
`default_nettype wire

### rtl/rwsd_in_stage.sv
// Input register slice for command words.
`default_nettype none
module rwsd_in_stage
  import rwsd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rwsd_cmd_t in_cmd,
  output logic           cmd_valid,
  input  wire logic      cmd_take,
  output rwsd_cmd_t      cmd
);

  assign in_ready = !cmd_valid || cmd_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      cmd_valid <= 1'b1;
    end else if (cmd_take) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= in_cmd;
    end
  end

endmodule
`default_nettype wire

### rtl/rwsd_core.sv
// Block decoder: header parse, burst/mask walk and write formation.
`default_nettype none
module rwsd_core
  import rwsd_pkg::*;
#(
  parameter int MASK_WIDTH = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_take,
  input  wire rwsd_cmd_t cmd,
  output logic           res_valid,
  input  wire logic      res_ready,
  output rwsd_result_t   res
);

  localparam int IDX_W = (MASK_WIDTH > 1) ? $clog2(MASK_WIDTH) : 1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DUMMY   = 2'd2
  } phase_t;

  phase_t                phase, phase_next;
  logic [BASE_W-1:0]     base_word_address, base_word_address_next;
  logic                  burst_mode, burst_mode_next;
  logic [COUNT_W-1:0]    remaining_count, remaining_count_next;
  logic [COUNT_W-1:0]    burst_offset, burst_offset_next;
  logic [MASK_WIDTH-1:0] remaining_mask, remaining_mask_next;
  ctx_t                  block_context, block_context_next;

  logic [BASE_W-1:0]     hdr_base;
  logic [COUNT_W-1:0]    hdr_count;
  logic [MASK_WIDTH-1:0] hdr_mask;
  logic                  hdr_payload;
  logic [IDX_W-1:0]      low_idx;
  logic [COUNT_W-1:0]    offset;
  logic [BASE_W:0]       word_sum;
  logic                  last;
  logic                  has_result;

  assign hdr_base  = cmd.stream_word[BASE_W-1:0];
  assign hdr_count = cmd.stream_word[FIELD_LSB +: COUNT_W];
  assign hdr_mask  = cmd.stream_word[FIELD_LSB +: MASK_WIDTH];

  // lowest set bit of the outstanding mask
  always_comb begin
    low_idx = '0;
    for (int i = MASK_WIDTH - 1; i >= 0; i--) begin
      if (remaining_mask[i]) begin
        low_idx = IDX_W'(i);
      end
    end
  end

  assign offset   = burst_mode ? burst_offset : COUNT_W'(low_idx);
  assign word_sum = {1'b0, base_word_address} + (BASE_W + 1)'(offset);

  always_comb begin
    phase_next             = phase;
    base_word_address_next = base_word_address;
    burst_mode_next        = burst_mode;
    remaining_count_next   = remaining_count;
    burst_offset_next      = burst_offset;
    remaining_mask_next    = remaining_mask;
    block_context_next     = block_context;
    res                    = '0;
    has_result             = 1'b0;
    hdr_payload            = 1'b0;
    last                   = 1'b0;
    case (phase)
      PH_DUMMY: begin
        phase_next = PH_HEADER;
      end
      PH_PAYLOAD: begin
        if (burst_mode) begin
          remaining_count_next = remaining_count - COUNT_W'(1);
          burst_offset_next    = burst_offset + COUNT_W'(1);
          last                 = (remaining_count == COUNT_W'(1));
          if (block_context == CTX_WEIGHTS_LO && burst_offset != '0) begin
            res.write_context = CTX_WEIGHTS_HI;
          end else begin
            res.write_context = block_context;
          end
        end else begin
          remaining_mask_next = remaining_mask & ~(MASK_WIDTH'(1) << low_idx);
          last                = (remaining_mask_next == '0);
          res.write_context   = CTX_MASKED;
        end
        has_result           = 1'b1;
        res.reg_byte_address = {word_sum, 2'b00};
        res.reg_value        = cmd.stream_word;
        res.block_done       = last;
        res.write_valid      = 1'b1;
        res.truncated        = !last && cmd.end_of_stream;
        if (cmd.end_of_stream) begin
          phase_next = PH_HEADER;
        end else if (last) begin
          phase_next = PH_DUMMY;
        end
      end
      default: begin
        base_word_address_next = hdr_base;
        burst_offset_next      = '0;
        if (!cmd.stream_word[MODE_BIT]) begin
          burst_mode_next      = 1'b1;
          remaining_count_next = hdr_count;
          remaining_mask_next  = '0;
          if (hdr_base == '0 && hdr_count == WEIGHTS_COUNT) begin
            block_context_next = CTX_WEIGHTS_LO;
          end else if (hdr_base == '0 && hdr_count == INPUT_COUNT) begin
            block_context_next = CTX_INPUT;
          end else begin
            block_context_next = CTX_PLAIN;
          end
          hdr_payload = (hdr_count != '0);
        end else begin
          burst_mode_next      = 1'b0;
          remaining_count_next = '0;
          remaining_mask_next  = hdr_mask;
          block_context_next   = CTX_MASKED;
          hdr_payload          = (hdr_mask != '0);
        end
        if (cmd.end_of_stream) begin
          phase_next    = PH_HEADER;
          has_result    = hdr_payload;
          res.truncated = 1'b1;
        end else begin
          phase_next = hdr_payload ? PH_PAYLOAD : PH_DUMMY;
        end
      end
    endcase
  end

  assign res_valid = cmd_valid && has_result;
  assign cmd_take  = cmd_valid && (!has_result || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      base_word_address <= '0;
      burst_mode        <= 1'b0;
      remaining_count   <= '0;
      burst_offset      <= '0;
      remaining_mask    <= '0;
      block_context     <= CTX_PLAIN;
    end else if (cmd_take) begin
      phase             <= phase_next;
      base_word_address <= base_word_address_next;
      burst_mode        <= burst_mode_next;
      remaining_count   <= remaining_count_next;
      burst_offset      <= burst_offset_next;
      remaining_mask    <= remaining_mask_next;
      block_context     <= block_context_next;
    end
  end

endmodule
`default_nettype wire

### rtl/rwsd_out_stage.sv
// Result register between the decoder and the master side.
`default_nettype none
module rwsd_out_stage
  import rwsd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         res_valid,
  output logic              res_ready,
  input  wire rwsd_result_t res,
  output logic              out_valid,
  input  wire logic         out_ready,
  output rwsd_result_t      out_item
);

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_item <= res;
    end
  end

endmodule
`default_nettype wire

### test/register_write_stream_decoder_tb.sv
// Self-checking testbench for the register write stream decoder.
`default_nettype none
module register_write_stream_decoder_tb;
  import rwsd_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_WORDS  = 470;
  localparam int LONG_HOLD     = 150;
  localparam int MAX_REPORTS   = 40;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DUMMY   = 2'd2
  } phase_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [WORD_W-1:0]    s_axis_tdata;   // [31:0] stream_word
  logic                 s_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [17:0] reg_byte_address, [49:18] reg_value, [55:50] zero
  logic [TDATA_W-1:0]   m_axis_tdata;
  logic                 m_axis_tlast;
  // [2:0] write_context, [3] write_valid, [4] truncated
  logic [TUSER_W-1:0]   m_axis_tuser;

  // decoder state mirrored for prediction
  phase_t               dec_phase  = PH_HEADER;
  logic [BASE_W-1:0]    dec_base   = '0;
  logic                 dec_burst  = 1'b0;
  logic [COUNT_W-1:0]   dec_count  = '0;
  logic [COUNT_W-1:0]   dec_offset = '0;
  logic [15:0]          dec_mask   = '0;
  ctx_t                 dec_ctx    = CTX_PLAIN;

  rwsd_result_t         pending_writes[$];
  rwsd_result_t         next_write;
  int                   errors = 0;
  int                   words_sent = 0;
  int                   idle_cycles = 0;
  int                   rx_hold_request = 0;
  bit                   no_gaps = 1'b0;

  register_write_stream_decoder dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicts the register write (if any) caused by one command word.
  function automatic void decode_word(input logic [WORD_W-1:0] w, input logic eos);
    rwsd_result_t res;
    logic         has_payload;
    logic         last;
    logic [5:0]   off;
    ctx_t         ctx;
    res = '0;
    if (dec_phase == PH_DUMMY) begin
      dec_phase = PH_HEADER;
      return;
    end
    if (dec_phase != PH_PAYLOAD) begin
      dec_base   = w[BASE_W-1:0];
      dec_offset = '0;
      if (!w[MODE_BIT]) begin
        dec_burst = 1'b1;
        dec_count = w[FIELD_LSB +: COUNT_W];
        dec_mask  = '0;
        if (dec_base == '0 && dec_count == WEIGHTS_COUNT)
          dec_ctx = CTX_WEIGHTS_LO;
        else if (dec_base == '0 && dec_count == INPUT_COUNT)
          dec_ctx = CTX_INPUT;
        else
          dec_ctx = CTX_PLAIN;
        has_payload = (dec_count != '0);
      end else begin
        dec_burst = 1'b0;
        dec_count = '0;
        dec_mask  = w[FIELD_LSB +: 16];
        dec_ctx   = CTX_MASKED;
        has_payload = (dec_mask != '0);
      end
      if (eos) begin
        dec_phase = PH_HEADER;
        if (has_payload) begin
          res.write_context = CTX_PLAIN;
          res.truncated     = 1'b1;
          pending_writes.push_back(res);
        end
      end else begin
        dec_phase = has_payload ? PH_PAYLOAD : PH_DUMMY;
      end
      return;
    end
    if (dec_burst) begin
      off = dec_offset;
      ctx = (dec_ctx == CTX_WEIGHTS_LO && off != '0) ? CTX_WEIGHTS_HI : dec_ctx;
      dec_count  = dec_count - 1'b1;
      dec_offset = dec_offset + 1'b1;
      last = (dec_count == '0);
    end else begin
      off = '0;
      for (int k = 15; k >= 0; k--)
        if (dec_mask[k]) off = 6'(k);
      ctx = CTX_MASKED;
      dec_mask[off[3:0]] = 1'b0;
      last = (dec_mask == '0);
    end
    res.reg_byte_address = (ADDR_W'(dec_base) + ADDR_W'(off)) << 2;
    res.reg_value        = w;
    res.write_context    = ctx;
    res.block_done       = last;
    res.write_valid      = 1'b1;
    res.truncated        = !last && eos;
    pending_writes.push_back(res);
    if (last)
      dec_phase = eos ? PH_HEADER : PH_DUMMY;
    else if (eos)
      dec_phase = PH_HEADER;
  endfunction

  function automatic void report_mismatch(input string what, input logic [63:0] want,
                                          input logic [63:0] got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endfunction

  // Predict on every accepted command word, check every accepted write.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_writes.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected write, expected none, actual tdata %0h tlast %0b tuser %0b",
                     $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
        end else begin
          next_write = pending_writes.pop_front();
          if (m_axis_tdata[17:0] !== next_write.reg_byte_address)
            report_mismatch("reg_byte_address", next_write.reg_byte_address, m_axis_tdata[17:0]);
          if (m_axis_tdata[49:18] !== next_write.reg_value)
            report_mismatch("reg_value", next_write.reg_value, m_axis_tdata[49:18]);
          if (m_axis_tdata[55:50] !== 6'b000000)
            report_mismatch("tdata padding", 0, m_axis_tdata[55:50]);
          if (m_axis_tuser[2:0] !== next_write.write_context)
            report_mismatch("write_context", next_write.write_context, m_axis_tuser[2:0]);
          if (m_axis_tlast !== next_write.block_done)
            report_mismatch("block_done", next_write.block_done, m_axis_tlast);
          if (m_axis_tuser[3] !== next_write.write_valid)
            report_mismatch("write_valid", next_write.write_valid, m_axis_tuser[3]);
          if (m_axis_tuser[4] !== next_write.truncated)
            report_mismatch("truncated", next_write.truncated, m_axis_tuser[4]);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        decode_word(s_axis_tdata, s_axis_tlast);
    end
  end

  // Watchdog: ends the run if no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stall before each write, or one long hold on request.
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (rx_hold_request > 0) begin
        stall = rx_hold_request;
        rx_hold_request = 0;
      end else if (no_gaps) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_word(input logic [WORD_W-1:0] w, input logic eos);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tlast  <= eos;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
  endtask

  function automatic logic [WORD_W-1:0] burst_header(input logic [BASE_W-1:0] addr,
                                                      input logic [COUNT_W-1:0] cnt);
    return {1'b0, 10'($urandom), cnt, addr};
  endfunction

  function automatic logic [WORD_W-1:0] masked_header(input logic [BASE_W-1:0] addr,
                                                       input logic [15:0] msk);
    return {1'b1, msk, addr};
  endfunction

  function automatic logic [WORD_W-1:0] payload_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_contexts();
    send_word(burst_header('0, WEIGHTS_COUNT), 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h1234_5678, 1'b0);
    send_word(burst_header('0, INPUT_COUNT), 1'b0);
    for (int i = 0; i < 10; i++)
      send_word(payload_value(), 1'b0);
    // end marker on a dummy word is ignored
    send_word(32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_extremes();
    send_word(burst_header('1, 6'd1), 1'b0);
    send_word(32'hA5A5_5A5A, 1'b0);
    send_word(32'h0, 1'b0);
    send_word(masked_header('1, 16'h8001), 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0, 1'b0);
    send_word(32'h0, 1'b0);
    send_word(burst_header(15'h0123, 6'd0), 1'b0);
    send_word(32'hDEAD_BEEF, 1'b0);
    send_word(masked_header(15'h4000, 16'h0000), 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_stream_end();
    // header with payload due, then header with none
    send_word(burst_header(15'h0040, 6'd4), 1'b1);
    send_word(masked_header(15'h0041, 16'h0000), 1'b1);
    // truncated mid payload
    send_word(burst_header(15'h0050, 6'd3), 1'b0);
    send_word(32'h1111_1111, 1'b0);
    send_word(32'h2222_2222, 1'b1);
    // end on the last payload word: no dummy follows
    send_word(masked_header(15'h0060, 16'h0003), 1'b0);
    send_word(32'h3333_3333, 1'b0);
    send_word(32'h4444_4444, 1'b1);
    send_word(burst_header(15'h0005, 6'd1), 1'b0);
    send_word(32'h5555_5555, 1'b0);
    send_word(32'h0, 1'b0);
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    rx_hold_request = LONG_HOLD;
    send_word(burst_header(15'h1234, 6'd40), 1'b0);
    for (int i = 0; i < 40; i++)
      send_word(payload_value(), 1'b0);
    send_word($urandom, 1'b0);
    no_gaps = 1'b0;
  endtask

  task automatic send_random_block();
    logic [BASE_W-1:0]  addr;
    logic [COUNT_W-1:0] cnt;
    logic [15:0]        msk;
    logic               eos;
    int                 n;
    no_gaps = ($urandom_range(0, 4) == 0);
    // stray word with a random end marker
    if ($urandom_range(0, 99) < 8) begin
      send_word($urandom, ($urandom_range(0, 3) == 0));
      return;
    end
    case ($urandom_range(0, 5))
      0:       addr = '0;
      1:       addr = '1;
      default: addr = BASE_W'($urandom);
    endcase
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 9))
        6:       cnt = '0;
        7:       cnt = WEIGHTS_COUNT;
        8:       cnt = INPUT_COUNT;
        9:       cnt = ($urandom_range(0, 3) == 0) ? '1 : COUNT_W'($urandom);
        default: cnt = COUNT_W'($urandom_range(1, 6));
      endcase
      n = cnt;
      eos = ($urandom_range(0, 39) == 0);
      send_word(burst_header(addr, cnt), eos);
    end else begin
      case ($urandom_range(0, 9))
        0:       msk = '0;
        1:       msk = '1;
        2, 3, 4: msk = 16'h1 << $urandom_range(0, 15);
        default: msk = 16'($urandom);
      endcase
      n = $countones(msk);
      eos = ($urandom_range(0, 39) == 0);
      send_word(masked_header(addr, msk), eos);
    end
    for (int i = 0; i < n && !eos; i++) begin
      eos = ($urandom_range(0, 39) == 0);
      send_word(payload_value(), eos);
    end
    if (!eos)
      send_word($urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_streams();
    int target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target)
      send_random_block();
    no_gaps = 1'b0;
  endtask

  initial begin
    int drain_cycles;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_contexts();
    test_extremes();
    test_stream_end();
    test_backpressure();
    test_random_streams();

    s_axis_tvalid <= 1'b0;
    drain_cycles = 0;
    while (pending_writes.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_writes.size() != 0) begin
      errors++;
      $display("%0t: writes missing, expected %0d more, actual none", $time,
               pending_writes.size());
    end
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire

### register_write_stream_decoder.f
+incdir+rtl
rtl/rwsd_pkg.sv
rtl/rwsd_in_stage.sv
rtl/rwsd_core.sv
rtl/rwsd_out_stage.sv
rtl/register_write_stream_decoder.sv
test/register_write_stream_decoder_tb.sv
